/* sv/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared widths, register indexes and reset values for the reconnect backoff
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 40;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RETRY_INITIAL   = 2'd0,
      CSR_RETRY_MAX       = 2'd1,
      CSR_CONNECT_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [TIME_W-1:0] RETRY_INITIAL_RST   = 32'd1000;
   localparam logic [TIME_W-1:0] RETRY_MAX_RST       = 32'd60000;
   localparam logic [TIME_W-1:0] CONNECT_TIMEOUT_RST = 32'd15000;

endpackage : rbc_pkg

`default_nettype wire

/* sv/reconnect_backoff_controller_core.sv */
// ----------------------------------------------------------------------------
// reconnect_backoff_controller_core
// Reconnect timer with exponential backoff, evaluated once per poll.
//
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  now_ms, link_up
// rsp      out        rsp_tvalid/rsp_tready  start, abort, connected, retry, delay
// csr      in         csr_we                 retry_initial, retry_max, timeout
//
// One poll is taken every cycle while the result stage is not stalled; an
// accepted transaction passes the input register and then the result
// register before its result is valid.
// The poll's arithmetic is a few 32-bit subtracts and compares and one add.
// Reset is synchronous; it clears control state and loads register defaults.
// A stalled result holds its register; the input stage keeps accepting as
// long as the result register will be free on the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module reconnect_backoff_controller_core
   import rbc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [31:0] now_ms, [32] link_up, [39:33] zero
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] start_attempt, [1] abort_attempt, [2] is_connected,
   // [3] retry_scheduled, [35:4] scheduled_delay_ms, [39:36] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [TIME_W-1:0] retry_initial_ff;
   logic [TIME_W-1:0] retry_max_ff;
   logic [TIME_W-1:0] timeout_ff;

   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic              s1_link_ff;

   logic              started_ff,    started_in;
   logic              connected_ff,  connected_in;
   logic              running_ff,    running_in;
   logic [TIME_W-1:0] start_time_ff, start_time_in;
   logic [TIME_W-1:0] next_time_ff,  next_time_in;
   logic [TIME_W-1:0] backoff_ff,    backoff_in;

   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              advance;
   logic [TIME_W-1:0] backoff_eff;
   logic [TIME_W-1:0] next_eff;
   logic [TIME_W-1:0] backoff_grown;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] wait_diff;
   logic [TIME_W-1:0] neg_backoff;
   logic              timed_out;
   logic              due_wait;
   logic              due_drop;
   logic              start_flag;
   logic              abort_flag;
   logic              sched_flag;
   logic [TIME_W-1:0] delay_val;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_initial_ff <= RETRY_INITIAL_RST;
         retry_max_ff     <= RETRY_MAX_RST;
         timeout_ff       <= CONNECT_TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RETRY_INITIAL:   retry_initial_ff <= csr_wdata;
            CSR_RETRY_MAX:       retry_max_ff     <= csr_wdata;
            CSR_CONNECT_TIMEOUT: timeout_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_now_ff  <= req_tdata[TIME_W-1:0];
         s1_link_ff <= req_tdata[TIME_W];
      end
   end

   always_comb begin
      backoff_eff   = started_ff ? backoff_ff : retry_initial_ff;
      next_eff      = started_ff ? next_time_ff : s1_now_ff;
      backoff_grown = (backoff_eff >= (retry_max_ff >> 1)) ? retry_max_ff
                                                           : {backoff_eff[TIME_W-2:0], 1'b0};
      elapsed       = s1_now_ff - start_time_ff;
      timed_out     = elapsed >= timeout_ff;
      wait_diff     = s1_now_ff - next_eff;
      due_wait      = !wait_diff[TIME_W-1];
      neg_backoff   = '0 - backoff_eff;
      due_drop      = !neg_backoff[TIME_W-1];

      started_in    = 1'b1;
      connected_in  = connected_ff;
      running_in    = running_ff;
      start_time_in = start_time_ff;
      next_time_in  = next_eff;
      backoff_in    = backoff_eff;
      start_flag    = 1'b0;
      abort_flag    = 1'b0;
      sched_flag    = 1'b0;
      delay_val     = '0;

      priority if (s1_link_ff) begin
         if (!connected_ff) begin
            connected_in = 1'b1;
            running_in   = 1'b0;
            backoff_in   = retry_initial_ff;
         end
      end else if (connected_ff) begin
         connected_in = 1'b0;
         running_in   = 1'b0;
         sched_flag   = 1'b1;
         delay_val    = backoff_eff;
         next_time_in = s1_now_ff + backoff_eff;
         backoff_in   = backoff_grown;
         if (due_drop) begin
            running_in    = 1'b1;
            start_time_in = s1_now_ff;
            start_flag    = 1'b1;
         end
      end else if (running_ff) begin
         if (timed_out) begin
            running_in   = 1'b0;
            abort_flag   = 1'b1;
            sched_flag   = 1'b1;
            delay_val    = backoff_eff;
            next_time_in = s1_now_ff + backoff_eff;
            backoff_in   = backoff_grown;
         end
      end else begin
         if (due_wait) begin
            running_in    = 1'b1;
            start_time_in = s1_now_ff;
            start_flag    = 1'b1;
         end
      end

      rsp_data_in = {4'b0000, delay_val, sched_flag, connected_in, abort_flag, start_flag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         connected_ff  <= 1'b0;
         running_ff    <= 1'b0;
         start_time_ff <= '0;
         next_time_ff  <= '0;
         backoff_ff    <= '0;
      end else if (advance) begin
         started_ff    <= started_in;
         connected_ff  <= connected_in;
         running_ff    <= running_in;
         start_time_ff <= start_time_in;
         next_time_ff  <= next_time_in;
         backoff_ff    <= backoff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A result never both starts and aborts an attempt.
   a_start_abort_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[1]))
      else $error("start and abort in one result");

   // An abort always schedules a retry.
   a_abort_schedules: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1]) |-> rsp_data_ff[3])
      else $error("abort without scheduled retry");

   // While connected, no attempt is started or aborted.
   a_connected_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> (!rsp_data_ff[0] && !rsp_data_ff[1]))
      else $error("attempt activity while connected");

   // A poll with the link up leaves the block connected with no attempt running.
   a_link_up_state: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_link_ff) |=> (connected_ff && !running_ff && started_ff))
      else $error("link up did not settle the connection state");

   // A stalled result holds its register until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule : reconnect_backoff_controller_core

`default_nettype wire
